>>> rtl/vdce_pkg.sv
// Shared types, constants and helpers of the voxel cube emitter.
// No dependencies.
package vdce_pkg;

  localparam int MaxResolution  = 32;
  localparam int CornersPerCube = 24;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 32;

  typedef enum logic [2:0] {
    ST_VERTEX   = 3'd0,
    ST_OCCUPIED = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CORNER_X   = 3'd0,
    CFG_CORNER_Y   = 3'd1,
    CFG_CORNER_Z   = 3'd2,
    CFG_BOX_DIM    = 3'd3,
    CFG_RESOLUTION = 3'd4,
    CFG_CAPACITY   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
  } vdce_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [7:0]         vertex_red;
    logic [7:0]         vertex_green;
    logic [7:0]         vertex_blue;
    logic [19:0]        vertex_number;
    logic               last;
  } vdce_out_t;

  // corner signs: bit0 x, bit1 y, bit2 z; set means plus half
  function automatic logic [2:0] corner_sign(logic [4:0] c);
    logic [2:0] s;
    case (c)
      5'd0:  s = 3'd4;  5'd1:  s = 3'd5;  5'd2:  s = 3'd7;  5'd3:  s = 3'd6;
      5'd4:  s = 3'd0;  5'd5:  s = 3'd2;  5'd6:  s = 3'd3;  5'd7:  s = 3'd1;
      5'd8:  s = 3'd6;  5'd9:  s = 3'd7;  5'd10: s = 3'd3;  5'd11: s = 3'd2;
      5'd12: s = 3'd4;  5'd13: s = 3'd0;  5'd14: s = 3'd1;  5'd15: s = 3'd5;
      5'd16: s = 3'd2;  5'd17: s = 3'd0;  5'd18: s = 3'd4;  5'd19: s = 3'd6;
      5'd20: s = 3'd3;  5'd21: s = 3'd7;  5'd22: s = 3'd5;  5'd23: s = 3'd1;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // point plus or minus half edge, saturated to signed 32 bit
  function automatic logic [31:0] sat_add(logic [31:0] p, logic [30:0] h, logic plus);
    logic [32:0] s;
    logic [31:0] r;
    if (plus) begin
      s = {p[31], p} + {2'b00, h};
    end else begin
      s = {p[31], p} - {2'b00, h};
    end
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/vdce_in_if.sv
// Input channel of the voxel cube emitter: point or clear request.
// Depends on vdce_pkg.
interface vdce_in_if;
  import vdce_pkg::*;
  logic     valid;
  logic     ready;
  vdce_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vdce_out_if.sv
// Result channel of the voxel cube emitter: vertices and status.
// Depends on vdce_pkg.
interface vdce_out_if;
  import vdce_pkg::*;
  logic      valid;
  logic      ready;
  vdce_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vdce_cfg_if.sv
// Register write channel of the voxel cube emitter.
// Depends on vdce_pkg.
interface vdce_cfg_if;
  import vdce_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/vdce_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module vdce_ram #(
  parameter int Width = 1,
  parameter int Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/voxel_dedup_cube_emitter.sv
// Channel   Dir  Payload                               Transaction when
// in_i      in   req_type, point xyz, colour          in_i.valid & in_i.ready
// out_o     out  status, corner xyz, colour, number    out_o.valid & out_o.ready
// cfg_i     in   register index, write data           cfg_i.valid (ready tied high)
//
// Point: 3 axis divisions plus the half edge division on one shared restoring
// divider, each yielding a 31+ResW bit quotient. Each axis adds a box check
// state (S_AXIS) and a set-up state (S_MUL), then S_ADDR_A, S_ADDR_B, S_READ
// and S_TEST do address and test-and-set, then 24 corner results follow, one a
// cycle while the sink takes them.
// Full refusal: S_IDLE goes straight to S_STATUS, which registers the status.
// Outside or occupied: status once the failing check is reached.
// Clear and reset each sweep all MaxResolution**3 bits of the occupancy RAM,
// one bit a cycle, and are not ready meanwhile.
// The output register holds a result under stall; the sequencer waits for it.
// Depends on vdce_pkg, vdce_*_if and vdce_ram.
module voxel_dedup_cube_emitter #(
  parameter int MaxResolution = vdce_pkg::MaxResolution
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdce_in_if.sink     in_i,
  vdce_out_if.source  out_o,
  vdce_cfg_if.sink    cfg_i
);
  import vdce_pkg::*;

  localparam int ResW  = $clog2(MaxResolution + 1);
  localparam int IdxW  = (MaxResolution > 1) ? $clog2(MaxResolution) : 1;
  localparam int Depth = MaxResolution * MaxResolution * MaxResolution;
  localparam int AddrW = $clog2(Depth);
  localparam int NumW  = 31 + ResW;
  localparam int CntW  = $clog2(NumW + 1);
  localparam int CornW = $clog2(CornersPerCube);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_AXIS, S_MUL, S_DIV, S_ADDR_A, S_ADDR_B,
    S_READ, S_TEST, S_EMIT, S_STATUS
  } state_e;

  state_e state_q;

  // configuration
  logic [31:0] corner_x_q, corner_y_q, corner_z_q;
  logic [30:0] box_dim_q;
  logic [5:0]  cfg_res_q;
  logic [19:0] capacity_q;

  // item context
  vdce_in_t          pt_q;
  logic [ResW-1:0]   res_q;
  logic [1:0]        axis_q;       // 0..2 axes, 3 half edge
  logic [30:0]       d_q;
  logic [IdxW-1:0]   idx_i_q, idx_j_q, idx_k_q;
  logic [30:0]       half_q;
  logic [2*ResW-1:0] addr_a_q;
  logic [AddrW-1:0]  addr_q;
  logic [CornW-1:0]  corner_q;
  logic [19:0]       count_q;
  logic [AddrW-1:0]  sweep_q;
  logic              clr_req_q;
  status_e           status_q;

  // shared divider
  logic [NumW-1:0] num_q, quo_q, quo_d;
  logic [30:0]     den_q, rem_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     rem_sh;
  logic            ge;

  vdce_out_t out_q;
  logic      out_valid_q, out_free;

  logic [ResW-1:0]   res_eff;
  logic              full;
  logic [31:0]       coord, corner;
  logic [32:0]       dd;
  logic              in_box;
  logic [3*ResW-1:0] addr_b;
  logic [2:0]        sgn;
  logic              ram_we, ram_wdata, ram_rdata;
  logic [AddrW-1:0]  ram_waddr;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    if (cfg_res_q == 6'd0) begin
      res_eff = ResW'(1);
    end else if (int'(cfg_res_q) > MaxResolution) begin
      res_eff = ResW'(MaxResolution);
    end else begin
      res_eff = ResW'(cfg_res_q);
    end
  end

  // compare against capacity - 24; a capacity below 24 refuses all
  assign full = (capacity_q < 20'(CornersPerCube)) ||
                (count_q >= capacity_q - 20'(CornersPerCube));

  always_comb begin
    unique case (axis_q)
      2'd0:    begin coord = pt_q.in_x; corner = corner_x_q; end
      2'd1:    begin coord = pt_q.in_y; corner = corner_y_q; end
      default: begin coord = pt_q.in_z; corner = corner_z_q; end
    endcase
  end

  assign dd     = {coord[31], coord} - {corner[31], corner};
  assign in_box = !dd[32] && (dd != 33'd0) && (dd < {2'b00, box_dim_q});

  // one restoring step: shift in the next numerator bit
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? 31'(rem_sh - {1'b0, den_q}) : rem_sh[30:0];
  assign quo_d  = {quo_q[NumW-2:0], ge};

  assign addr_b = (3*ResW)'(addr_a_q) * (3*ResW)'(res_q) + (3*ResW)'(idx_i_q);
  assign sgn    = corner_sign(5'(corner_q));

  assign ram_we    = (state_q == S_SWEEP) || (state_q == S_TEST && !ram_rdata);
  assign ram_waddr = (state_q == S_SWEEP) ? sweep_q : addr_q;
  assign ram_wdata = (state_q != S_SWEEP);

  vdce_ram #(.Width(1), .Depth(Depth)) u_occ (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      clr_req_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      corner_x_q  <= '0;
      corner_y_q  <= '0;
      corner_z_q  <= '0;
      box_dim_q   <= 31'd65536;
      cfg_res_q   <= 6'd32;
      capacity_q  <= 20'd786432;
      axis_q      <= '0;
      cnt_q       <= '0;
      corner_q    <= '0;
      status_q    <= ST_VERTEX;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_CORNER_X:   corner_x_q <= cfg_i.data;
          CFG_CORNER_Y:   corner_y_q <= cfg_i.data;
          CFG_CORNER_Z:   corner_z_q <= cfg_i.data;
          CFG_BOX_DIM:    box_dim_q  <= cfg_i.data[30:0];
          CFG_RESOLUTION: cfg_res_q  <= cfg_i.data[5:0];
          CFG_CAPACITY:   capacity_q <= cfg_i.data[19:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_SWEEP: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == AddrW'(Depth - 1)) begin
            sweep_q <= '0;
            if (clr_req_q) begin
              clr_req_q <= 1'b0;
              status_q  <= ST_CLEARED;
              state_q   <= S_STATUS;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            pt_q   <= in_i.data;
            res_q  <= res_eff;
            axis_q <= 2'd0;
            if (in_i.data.req_type) begin
              count_q   <= '0;
              clr_req_q <= 1'b1;
              sweep_q   <= '0;
              state_q   <= S_SWEEP;
            end else if (full) begin
              status_q <= ST_FULL;
              state_q  <= S_STATUS;
            end else begin
              state_q <= S_AXIS;
            end
          end
        end
        S_AXIS: begin
          d_q <= dd[30:0];
          if (!in_box) begin
            status_q <= ST_OUTSIDE;
            state_q  <= S_STATUS;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          num_q   <= {31'd0, res_q} * {{ResW{1'b0}}, d_q};
          den_q   <= box_dim_q;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          num_q <= {num_q[NumW-2:0], 1'b0};
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(NumW - 1)) begin
            unique case (axis_q)
              2'd0: idx_i_q <= quo_d[IdxW-1:0];
              2'd1: idx_j_q <= quo_d[IdxW-1:0];
              2'd2: idx_k_q <= quo_d[IdxW-1:0];
              2'd3: half_q  <= quo_d[30:0];
            endcase
            unique case (axis_q)
              2'd0, 2'd1: begin
                axis_q  <= axis_q + 1'b1;
                state_q <= S_AXIS;
              end
              2'd2: begin
                // half edge: box_dim / (2 * res)
                axis_q  <= 2'd3;
                num_q   <= {{ResW{1'b0}}, box_dim_q};
                den_q   <= 31'({res_q, 1'b0});
                rem_q   <= '0;
                quo_q   <= '0;
                cnt_q   <= '0;
                state_q <= S_DIV;
              end
              2'd3: state_q <= S_ADDR_A;
            endcase
          end
        end
        S_ADDR_A: begin
          addr_a_q <= (2*ResW)'(idx_k_q) * (2*ResW)'(res_q) + (2*ResW)'(idx_j_q);
          state_q  <= S_ADDR_B;
        end
        S_ADDR_B: begin
          if (addr_b > (3*ResW)'(Depth - 1)) begin
            addr_q <= AddrW'(Depth - 1);
          end else begin
            addr_q <= AddrW'(addr_b);
          end
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_TEST;
        end
        S_TEST: begin
          corner_q <= '0;
          if (ram_rdata) begin
            status_q <= ST_OCCUPIED;
            state_q  <= S_STATUS;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_q.status        <= ST_VERTEX;
            out_q.vertex_x      <= sat_add(pt_q.in_x, half_q, sgn[0]);
            out_q.vertex_y      <= sat_add(pt_q.in_y, half_q, sgn[1]);
            out_q.vertex_z      <= sat_add(pt_q.in_z, half_q, sgn[2]);
            out_q.vertex_red    <= pt_q.in_red;
            out_q.vertex_green  <= pt_q.in_green;
            out_q.vertex_blue   <= pt_q.in_blue;
            out_q.vertex_number <= count_q + 20'(corner_q);
            out_q.last          <= (corner_q == CornW'(CornersPerCube - 1));
            corner_q            <= corner_q + 1'b1;
            if (corner_q == CornW'(CornersPerCube - 1)) begin
              count_q <= count_q + 20'(CornersPerCube);
              state_q <= S_IDLE;
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '0;
            out_q.status <= status_q;
            out_q.last  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/vdce_chk.sv
// Port-level checks of the voxel cube emitter, bound to the top level.
// Depends on vdce_pkg and voxel_dedup_cube_emitter.
module vdce_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input vdce_pkg::vdce_out_t out_data_i
);
  import vdce_pkg::*;

  // busy once an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again straight after a transaction");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != ST_VERTEX |-> out_data_i.last)
    else $error("status result without last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != ST_VERTEX |->
      out_data_i.vertex_x == 32'd0 && out_data_i.vertex_number == 20'd0 &&
      out_data_i.vertex_red == 8'd0)
    else $error("status result carries vertex data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");
endmodule

bind voxel_dedup_cube_emitter vdce_chk u_vdce_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> tb/sv/vdce_tb_pkg.sv
// Request codes shared by the emitter testbench files.
// No dependencies.
`timescale 1ns / 100ps
package vdce_tb_pkg;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

endpackage

>>> tb/sv/vdce_checker.sv
// Scoreboard of the voxel cube emitter: follows register writes, predicts the
// cube corners or status of each point, compares them. Depends on vdce_pkg,
// vdce_tb_pkg and the vdce_*_if interfaces.
`timescale 1ns / 100ps
module vdce_checker (
  input  logic clk_i,
  input  logic rst_ni,
  vdce_in_if   in_mon,
  vdce_out_if  out_mon,
  vdce_cfg_if  cfg_mon,
  output int   fail_count,
  output int   due_count
);
  import vdce_pkg::*;
  import vdce_tb_pkg::*;

  // sign pattern per corner, bit0 x, bit1 y, bit2 z; set is plus half
  localparam logic [2:0] FACE_SIGNS [CornersPerCube] = '{
    3'd4, 3'd5, 3'd7, 3'd6, 3'd0, 3'd2, 3'd3, 3'd1,
    3'd6, 3'd7, 3'd3, 3'd2, 3'd4, 3'd0, 3'd1, 3'd5,
    3'd2, 3'd0, 3'd4, 3'd6, 3'd3, 3'd7, 3'd5, 3'd1
  };

  logic signed [31:0] corner_x, corner_y, corner_z;
  logic [30:0]        box_len;
  logic [5:0]         res_reg;
  logic [19:0]        capacity;
  bit                 occupied [MaxResolution**3];
  logic [19:0]        vertex_total;
  vdce_out_t          due_results [$];

  task automatic report(string field, longint got, longint want);
    $display("[%0t] %s: got %0h want %0h", $time, field, got, want);
    fail_count++;
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_cube(vdce_in_t pt);
    longint    px, py, pz, dx, dy, dz, half, r, addr;
    logic [2:0] s;
    vdce_out_t o;
    o = '0;
    o.last = 1'b1;
    if (pt.req_type == REQ_CLEAR) begin
      foreach (occupied[n]) occupied[n] = 1'b0;
      vertex_total = '0;
      o.status = ST_CLEARED;
      due_results.push_back(o);
      return;
    end
    if (longint'(vertex_total) >= longint'(capacity) - CornersPerCube) begin
      o.status = ST_FULL;
      due_results.push_back(o);
      return;
    end
    px = longint'($signed(pt.in_x));
    py = longint'($signed(pt.in_y));
    pz = longint'($signed(pt.in_z));
    dx = px - longint'(corner_x);
    dy = py - longint'(corner_y);
    dz = pz - longint'(corner_z);
    if (!(dx > 0 && dx < longint'(box_len) && dy > 0 && dy < longint'(box_len) &&
          dz > 0 && dz < longint'(box_len))) begin
      o.status = ST_OUTSIDE;
      due_results.push_back(o);
      return;
    end
    r = longint'(res_reg);
    if (r < 1) r = 1;
    if (r > MaxResolution) r = MaxResolution;
    addr = (r * dx) / longint'(box_len) + ((r * dy) / longint'(box_len)) * r +
           ((r * dz) / longint'(box_len)) * r * r;
    if (occupied[addr]) begin
      o.status = ST_OCCUPIED;
      due_results.push_back(o);
      return;
    end
    occupied[addr] = 1'b1;
    half = longint'(box_len) / (2 * r);
    for (int c = 0; c < CornersPerCube; c++) begin
      s = FACE_SIGNS[c];
      o.status        = ST_VERTEX;
      o.vertex_x      = clamp32(s[0] ? px + half : px - half);
      o.vertex_y      = clamp32(s[1] ? py + half : py - half);
      o.vertex_z      = clamp32(s[2] ? pz + half : pz - half);
      o.vertex_red    = pt.in_red;
      o.vertex_green  = pt.in_green;
      o.vertex_blue   = pt.in_blue;
      o.vertex_number = vertex_total + 20'(c);
      o.last          = (c == CornersPerCube - 1);
      due_results.push_back(o);
    end
    vertex_total = vertex_total + 20'(CornersPerCube);
  endtask

  task automatic compare(vdce_out_t got, vdce_out_t want);
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.vertex_x !== want.vertex_x) report("vertex_x", got.vertex_x, want.vertex_x);
    if (got.vertex_y !== want.vertex_y) report("vertex_y", got.vertex_y, want.vertex_y);
    if (got.vertex_z !== want.vertex_z) report("vertex_z", got.vertex_z, want.vertex_z);
    if (got.vertex_red !== want.vertex_red)
      report("vertex_red", got.vertex_red, want.vertex_red);
    if (got.vertex_green !== want.vertex_green)
      report("vertex_green", got.vertex_green, want.vertex_green);
    if (got.vertex_blue !== want.vertex_blue)
      report("vertex_blue", got.vertex_blue, want.vertex_blue);
    if (got.vertex_number !== want.vertex_number)
      report("vertex_number", got.vertex_number, want.vertex_number);
    if (got.last !== want.last) report("last", got.last, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_x = '0;
      corner_y = '0;
      corner_z = '0;
      box_len  = 31'd65536;
      res_reg  = 6'd32;
      capacity = 20'd786432;
      foreach (occupied[n]) occupied[n] = 1'b0;
      vertex_total = '0;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CFG_CORNER_X:   corner_x = cfg_mon.data;
          CFG_CORNER_Y:   corner_y = cfg_mon.data;
          CFG_CORNER_Z:   corner_z = cfg_mon.data;
          CFG_BOX_DIM:    box_len  = cfg_mon.data[30:0];
          CFG_RESOLUTION: res_reg  = cfg_mon.data[5:0];
          CFG_CAPACITY:   capacity = cfg_mon.data[19:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0)
          report("result with none due", longint'(out_mon.data.status), 0);
        else compare(out_mon.data, due_results.pop_front());
      end
      if (in_mon.valid && in_mon.ready) predict_cube(in_mon.data);
    end
    due_count = due_results.size();
  end

endmodule

>>> tb/sv/voxel_dedup_cube_emitter_tb.sv
// Top of the voxel cube emitter testbench: clock, reset, stimulus, idling and
// the verdict. Depends on vdce_pkg, vdce_tb_pkg, the interfaces and vdce_checker.
`timescale 1ns / 100ps
module voxel_dedup_cube_emitter_tb;
  import vdce_pkg::*;
  import vdce_tb_pkg::*;

  // no transaction for this many cycles means a hang; a clear or the reset
  // sweep alone stays quiet while the whole occupancy RAM is written
  localparam int WATCHDOG_LIMIT = 150000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fails, due;
  int   send_idle_pct, recv_idle_pct;
  int   quiet_cycles = 0;

  // recent points, replayed to hit occupied voxels
  logic signed [31:0] seen_x [8], seen_y [8], seen_z [8];

  always #1 clk_i = ~clk_i;

  vdce_in_if  in_ch ();
  vdce_out_if out_ch ();
  vdce_cfg_if cfg_ch ();

  voxel_dedup_cube_emitter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  vdce_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fails),
    .due_count  (due)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hang detection: any transaction on any channel restarts the count
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[voxel_dedup_cube_emitter] ERROR");
      $finish;
    end
  end

  function automatic vdce_in_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vdce_in_t it;
    it.req_type = REQ_ADD;
    it.in_x     = x;
    it.in_y     = y;
    it.in_z     = z;
    it.in_red   = 8'($urandom);
    it.in_green = 8'($urandom);
    it.in_blue  = 8'($urandom);
    return it;
  endfunction

  function automatic vdce_in_t make_clear();
    vdce_in_t it;
    it = make_point($urandom, $urandom, $urandom);
    it.req_type = REQ_CLEAR;
    return it;
  endfunction

  // valid stays high across back-to-back transactions; it is only lowered
  // when a gap is inserted, so it never gets two assignments in one step
  task automatic send(vdce_in_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (due != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(cfg_idx_e idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [31:0] box, logic [31:0] res, logic [31:0] cap);
    settle();
    reg_write(CFG_CORNER_X, cx);
    reg_write(CFG_CORNER_Y, cy);
    reg_write(CFG_CORNER_Z, cz);
    reg_write(CFG_BOX_DIM, box);
    reg_write(CFG_RESOLUTION, res);
    reg_write(CFG_CAPACITY, cap);
  endtask

  // mostly points inside the box, some replays of recent points (occupied),
  // some full-range noise (outside) and the odd clear
  task automatic random_points(int count, logic [31:0] cx, logic [31:0] cy,
                               logic [31:0] cz, logic [31:0] box);
    int pick, slot;
    logic [31:0] hi, x, y, z;
    hi = (box > 1) ? box - 1 : 1;
    send(make_clear());
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      slot = $urandom_range(7);
      if (pick < 2) begin
        send(make_clear());
      end else if (pick < 12) begin
        send(make_point($urandom, $urandom, $urandom));
      end else if (pick < 26) begin
        send(make_point(seen_x[slot], seen_y[slot], seen_z[slot]));
      end else begin
        x = cx + $urandom_range(hi, 1);
        y = cy + $urandom_range(hi, 1);
        z = cz + $urandom_range(hi, 1);
        seen_x[slot] = x;
        seen_y[slot] = y;
        seen_z[slot] = z;
        send(make_point(x, y, z));
      end
    end
  endtask

  initial begin
    vdce_in_t it;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    send_idle_pct = 14;
    recv_idle_pct = 74;
    foreach (seen_x[n]) begin
      seen_x[n] = 32'd1;
      seen_y[n] = 32'd1;
      seen_z[n] = 32'd1;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset grid is (0, 1.0) with 32 voxels per edge
    it = make_point(32'd1, 32'd1, 32'd1);
    it.in_red = 8'h00; it.in_green = 8'h00; it.in_blue = 8'h00;
    send(it);
    send(make_point(32'd1, 32'd1, 32'd1));            // same voxel again
    send(make_point(32'd0, 32'd5, 32'd5));            // on the lower face
    send(make_point(32'd65536, 32'd1, 32'd1));        // on the upper face
    it = make_point(32'd65535, 32'd65535, 32'd65535); // last voxel
    it.in_red = 8'hFF; it.in_green = 8'hFF; it.in_blue = 8'hFF;
    send(it);
    send(make_point(32'hFFFF_FFFF, 32'd7, 32'd7));    // negative offset
    send(make_clear());
    send(make_point(32'd1, 32'd1, 32'd1));            // free again after clear

    // resolution below range clamps to one voxel, above range to the maximum
    settle();
    reg_write(CFG_RESOLUTION, 32'd0);
    send(make_clear());
    send(make_point(32'd30000, 32'd30000, 32'd30000));
    send(make_point(32'd100, 32'd100, 32'd100));
    settle();
    reg_write(CFG_RESOLUTION, 32'd63);
    send(make_point(32'd6149, 32'd6149, 32'd6149));

    // capacity below one cube refuses everything; 48 allows a single cube
    settle();
    reg_write(CFG_CAPACITY, 32'd0);
    send(make_point(32'd9000, 32'd9000, 32'd9000));
    settle();
    reg_write(CFG_CAPACITY, 32'd48);
    send(make_clear());
    send(make_point(32'd9000, 32'd9000, 32'd9000));
    send(make_point(32'd20000, 32'd20000, 32'd20000));

    // zero box: nothing is inside
    settle();
    reg_write(CFG_BOX_DIM, 32'd0);
    send(make_point(32'd1, 32'd1, 32'd1));

    // widest box at both ends of the range, half edge saturates the corners
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
             32'd786432);
    send(make_clear());
    send(make_point(32'h8000_0001, 32'h8000_0001, 32'h8000_0001));
    set_grid(32'd1, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'd786432);
    send(make_clear());
    send(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

    // random phases, idling pattern changes with each
    set_grid(-32'sd196608, -32'sd196608, -32'sd196608, 32'd524288, 32'd6, 32'd786432);
    random_points(100, -32'sd196608, -32'sd196608, -32'sd196608, 32'd524288);

    settle();
    send_idle_pct = 74;
    recv_idle_pct = 14;
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd32,
             32'd960);
    random_points(95, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);

    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(32'd1000, 32'd1000, 32'd1000, 32'd12345, 32'd3, 32'd786432);
    random_points(95, 32'd1000, 32'd1000, 32'd1000, 32'd12345);

    settle();
    repeat (64) @(posedge clk_i);
    if (fails == 0 && due == 0) begin
      $display("[voxel_dedup_cube_emitter] OK");
    end else begin
      $display("[voxel_dedup_cube_emitter] ERROR");
    end
    $finish;
  end

endmodule
